// File: hw/rtl/sync_length_checksum_frame_parser_core_assert.svh
// Assertion macros shared by the frame parser RTL.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_PARSER_CORE_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLCFP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLCFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/slcfp_pkg.sv
// Types and constants shared by the frame parser modules.
// No dependencies; the fifo, front, back and top files refer to it by scoped names.
`default_nettype none

package slcfp_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int IDX_W  = 5;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register index as decoded from the word address.
  localparam logic REG_SYNC  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'd46;
  localparam logic [LEN_W-1:0]  LIMIT_RESET = 6'd32;

  typedef enum logic [4:0] {
    PH_SYNC  = 5'b00001,
    PH_CMD   = 5'b00010,
    PH_LEN   = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_HOLD = 3'b100
  } back_state_e;

  // One checked frame waiting for emission.
  typedef struct packed {
    logic [BYTE_W-1:0] cmd;
    logic [LEN_W-1:0]  len;
    logic              bank;
  } desc_t;

  // Payload bank handed back by the emitter once a frame is fully sent.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

`default_nettype wire

// File: hw/rtl/slcfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module slcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/slcfp_fifo.sv
// Two-entry queue of checked frame descriptors between parser and emitter.
// Depends on slcfp_pkg.
`default_nettype none

module slcfp_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire slcfp_pkg::desc_t desc_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic             empty_o,
  output      slcfp_pkg::desc_t desc_o
);

  slcfp_pkg::desc_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign desc_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/slcfp_front.sv
// Byte parser: sync hunt, header, payload capture into the bank RAM, checksum check.
// Depends on slcfp_pkg and the shared assertion macros.
`default_nettype none

`include "sync_length_checksum_frame_parser_core_assert.svh"

module slcfp_front #(
  parameter int MAX_PAYLOAD = 32,
  localparam int IdxW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int AddrW = IdxW + 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [slcfp_pkg::BYTE_W-1:0]   sync_value_i,
  input  wire logic [slcfp_pkg::LEN_W-1:0]    length_limit_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [slcfp_pkg::BYTE_W-1:0]   rx_byte_i,
  output      logic                           ram_we_o,
  output      logic [AddrW-1:0]               ram_waddr_o,
  output      logic [slcfp_pkg::BYTE_W-1:0]   ram_wdata_o,
  output      logic                           push_o,
  output      slcfp_pkg::desc_t               desc_o,
  input  wire logic                           fifo_full_i,
  input  wire slcfp_pkg::rel_t                rel_i
);

  localparam logic [slcfp_pkg::BYTE_W-1:0] MaxLen = slcfp_pkg::BYTE_W'(MAX_PAYLOAD);

  slcfp_pkg::phase_e                phase_q, phase_d;
  logic [slcfp_pkg::BYTE_W-1:0]     cmd_q, cmd_d;
  logic [slcfp_pkg::LEN_W-1:0]      len_q, len_d;
  logic [slcfp_pkg::LEN_W-1:0]      fill_q, fill_d;
  logic [slcfp_pkg::BYTE_W-1:0]     sum_q, sum_d;
  logic                             wbank_q, wbank_d;
  logic [1:0]                       busy_q, busy_d;
  logic [slcfp_pkg::BYTE_W-1:0]     limit;
  logic [slcfp_pkg::LEN_W:0]        fill_inc;
  logic                             accept;
  logic                             is_sync;

  // The usable limit never exceeds the payload store.
  always_comb begin
    if ({2'b00, length_limit_i} > MaxLen) begin
      limit = MaxLen;
    end else begin
      limit = {2'b00, length_limit_i};
    end
  end

  assign fill_inc = {1'b0, fill_q} + 1'b1;
  assign is_sync  = (rx_byte_i == sync_value_i);

  // Stall while the bank to be filled is still being emitted, or while a
  // checksum byte might need a queue slot that is not there.
  assign in_ready_o = !(((phase_q == slcfp_pkg::PH_DATA) && busy_q[wbank_q]) ||
                        ((phase_q == slcfp_pkg::PH_CHECK) && fifo_full_i));
  assign accept = in_valid_i && in_ready_o;

  assign ram_waddr_o = {wbank_q, fill_q[IdxW-1:0]};
  assign ram_wdata_o = rx_byte_i;
  assign desc_o      = '{cmd: cmd_q, len: len_q, bank: wbank_q};

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    wbank_d  = wbank_q;
    ram_we_o = 1'b0;
    push_o   = 1'b0;
    if (accept) begin
      unique case (phase_q)
        slcfp_pkg::PH_CMD: begin
          cmd_d   = rx_byte_i;
          sum_d   = rx_byte_i;
          phase_d = slcfp_pkg::PH_LEN;
        end
        slcfp_pkg::PH_LEN: begin
          if (rx_byte_i > limit) begin
            if (is_sync) begin
              fill_d  = '0;
              sum_d   = '0;
              phase_d = slcfp_pkg::PH_CMD;
            end else begin
              phase_d = slcfp_pkg::PH_SYNC;
            end
          end else begin
            len_d   = rx_byte_i[slcfp_pkg::LEN_W-1:0];
            sum_d   = sum_q + rx_byte_i;
            phase_d = (rx_byte_i == '0) ? slcfp_pkg::PH_CHECK : slcfp_pkg::PH_DATA;
          end
        end
        slcfp_pkg::PH_DATA: begin
          ram_we_o = 1'b1;
          fill_d   = fill_inc[slcfp_pkg::LEN_W-1:0];
          sum_d    = sum_q + rx_byte_i;
          if (fill_inc >= {1'b0, len_q}) begin
            phase_d = slcfp_pkg::PH_CHECK;
          end
        end
        slcfp_pkg::PH_CHECK: begin
          if (rx_byte_i == ~sum_q) begin
            push_o  = 1'b1;
            phase_d = slcfp_pkg::PH_SYNC;
            if (len_q != '0) begin
              wbank_d = ~wbank_q;
            end
          end else if (is_sync) begin
            fill_d  = '0;
            sum_d   = '0;
            phase_d = slcfp_pkg::PH_CMD;
          end else begin
            phase_d = slcfp_pkg::PH_SYNC;
          end
        end
        default: begin
          if (is_sync) begin
            fill_d  = '0;
            sum_d   = '0;
            phase_d = slcfp_pkg::PH_CMD;
          end else begin
            phase_d = slcfp_pkg::PH_SYNC;
          end
        end
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (push_o && (len_q != '0)) begin
      busy_d[wbank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= slcfp_pkg::PH_SYNC;
      cmd_q   <= '0;
      len_q   <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      wbank_q <= 1'b0;
      busy_q  <= 2'b00;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      wbank_q <= wbank_d;
      busy_q  <= busy_d;
    end
  end

  `SLCFP_ASSERT_IMPLY(a_write_free_bank, clk_i, rst_ni, ram_we_o, !busy_q[wbank_q], "payload write into a bank still being emitted")
  `SLCFP_ASSERT_NEXT(a_bank_flips, clk_i, rst_ni, push_o && (len_q != '0), wbank_q != $past(wbank_q), "bank did not advance after a stored frame")

endmodule

`default_nettype wire

// File: hw/rtl/slcfp_back.sv
// Emitter: sends one result per payload byte of each queued frame, or one for an empty frame.
// Depends on slcfp_pkg and the shared assertion macros.
`default_nettype none

`include "sync_length_checksum_frame_parser_core_assert.svh"

module slcfp_back #(
  parameter int MAX_PAYLOAD = 32,
  localparam int IdxW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int AddrW = IdxW + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fifo_empty_i,
  input  wire slcfp_pkg::desc_t             desc_i,
  output      logic                         pop_o,
  output      logic                         ram_re_o,
  output      logic [AddrW-1:0]             ram_raddr_o,
  input  wire logic [slcfp_pkg::BYTE_W-1:0] ram_rdata_i,
  output      slcfp_pkg::rel_t              rel_o,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [slcfp_pkg::BYTE_W-1:0] frame_command_o,
  output      logic [slcfp_pkg::LEN_W-1:0]  frame_length_o,
  output      logic [slcfp_pkg::IDX_W-1:0]  byte_index_o,
  output      logic [slcfp_pkg::BYTE_W-1:0] payload_byte_o,
  output      logic                         has_payload_o,
  output      logic                         last_o
);

  slcfp_pkg::back_state_e        st_q, st_d;
  logic [slcfp_pkg::BYTE_W-1:0]  cmd_q, cmd_d;
  logic [slcfp_pkg::LEN_W-1:0]   len_q, len_d;
  logic                          bank_q, bank_d;
  logic [slcfp_pkg::LEN_W-1:0]   cnt_q, cnt_d;
  logic [slcfp_pkg::LEN_W:0]     cnt_inc;
  logic                          ov_q, ov_d;
  logic [slcfp_pkg::BYTE_W-1:0]  od_q, od_d;
  logic [slcfp_pkg::IDX_W-1:0]   oidx_q, oidx_d;
  logic                          ohas_q, ohas_d;
  logic                          olast_q, olast_d;

  assign cnt_inc = {1'b0, cnt_q} + 1'b1;

  assign out_valid_o     = ov_q;
  assign frame_command_o = cmd_q;
  assign frame_length_o  = len_q;
  assign byte_index_o    = oidx_q;
  assign payload_byte_o  = od_q;
  assign has_payload_o   = ohas_q;
  assign last_o          = olast_q;

  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    bank_d      = bank_q;
    cnt_d       = cnt_q;
    ov_d        = ov_q;
    od_d        = od_q;
    oidx_d      = oidx_q;
    ohas_d      = ohas_q;
    olast_d     = olast_q;
    pop_o       = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = {bank_q, cnt_q[IdxW-1:0]};
    rel_o       = '{valid: 1'b0, bank: bank_q};
    unique case (st_q)
      slcfp_pkg::ST_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o  = 1'b1;
          cmd_d  = desc_i.cmd;
          len_d  = desc_i.len;
          bank_d = desc_i.bank;
          cnt_d  = '0;
          if (desc_i.len == '0) begin
            // An empty frame still yields one marker result.
            ov_d    = 1'b1;
            od_d    = '0;
            oidx_d  = '0;
            ohas_d  = 1'b0;
            olast_d = 1'b1;
            st_d    = slcfp_pkg::ST_HOLD;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = {desc_i.bank, {IdxW{1'b0}}};
            st_d        = slcfp_pkg::ST_READ;
          end
        end
      end
      slcfp_pkg::ST_READ: begin
        ov_d    = 1'b1;
        od_d    = ram_rdata_i;
        oidx_d  = cnt_q[slcfp_pkg::IDX_W-1:0];
        ohas_d  = 1'b1;
        olast_d = (cnt_inc == {1'b0, len_q});
        st_d    = slcfp_pkg::ST_HOLD;
      end
      slcfp_pkg::ST_HOLD: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          if (olast_q) begin
            rel_o.valid = ohas_q;
            st_d        = slcfp_pkg::ST_IDLE;
          end else begin
            cnt_d       = cnt_inc[slcfp_pkg::LEN_W-1:0];
            ram_re_o    = 1'b1;
            ram_raddr_o = {bank_q, cnt_inc[IdxW-1:0]};
            st_d        = slcfp_pkg::ST_READ;
          end
        end
      end
      default: begin
        st_d = slcfp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= slcfp_pkg::ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    len_q   <= len_d;
    bank_q  <= bank_d;
    cnt_q   <= cnt_d;
    od_q    <= od_d;
    oidx_q  <= oidx_d;
    ohas_q  <= ohas_d;
    olast_q <= olast_d;
  end

  `SLCFP_ASSERT_IMPLY(a_no_result_while_fetching, clk_i, rst_ni, st_q == slcfp_pkg::ST_READ, !ov_q, "result shown while its byte is still being fetched")
  `SLCFP_ASSERT_IMPLY(a_index_in_frame, clk_i, rst_ni, ov_q && ohas_q, cnt_q < len_q, "payload index beyond frame length")

endmodule

`default_nettype wire

// File: hw/rtl/sync_length_checksum_frame_parser_core.sv
// Top level of the sync / length / checksum frame parser.
// Depends on slcfp_pkg, slcfp_front, slcfp_fifo, slcfp_back and slcfp_ram.
//
//   Channel   Direction  Handshake                   Payload
//   rx        in         in_valid_i / in_ready_o      rx_byte_i
//   result    out        out_valid_o / out_ready_i    frame_command_o .. last_o
//   config    in         APB psel/penable/pwrite      paddr, pwdata, prdata
//
// The parser takes one byte per cycle. It stalls only while the payload bank
// it must fill is still being emitted, or on a checksum byte when the queue
// of checked frames is full. The emitter picks up each frame from the queue,
// then reads the RAM and presents one result at a time for each payload byte.
// Reset is asynchronous and active low; it returns the parser to sync hunt,
// empties the queue and loads the register defaults.
`default_nettype none

module sync_length_checksum_frame_parser_core #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Received bytes.
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [slcfp_pkg::BYTE_W-1:0]  rx_byte_i,
  // Frame results.
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [slcfp_pkg::BYTE_W-1:0]  frame_command_o,
  output      logic [slcfp_pkg::LEN_W-1:0]   frame_length_o,
  output      logic [slcfp_pkg::IDX_W-1:0]   byte_index_o,
  output      logic [slcfp_pkg::BYTE_W-1:0]  payload_byte_o,
  output      logic                          has_payload_o,
  output      logic                          last_o,
  // Register port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [slcfp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [slcfp_pkg::DATA_W-1:0]  pwdata,
  output      logic [slcfp_pkg::DATA_W-1:0]  prdata,
  output      logic                          pready
);

  localparam int IdxW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int AddrW    = IdxW + 1;
  localparam int RamDepth = 2 ** AddrW;

  logic [slcfp_pkg::BYTE_W-1:0] sync_q;
  logic [slcfp_pkg::LEN_W-1:0]  limit_q;
  logic                         cfg_wr;

  logic                         ram_we;
  logic [AddrW-1:0]             ram_waddr;
  logic [slcfp_pkg::BYTE_W-1:0] ram_wdata;
  logic                         ram_re;
  logic [AddrW-1:0]             ram_raddr;
  logic [slcfp_pkg::BYTE_W-1:0] ram_rdata;

  logic                         push;
  logic                         pop;
  logic                         fifo_full;
  logic                         fifo_empty;
  slcfp_pkg::desc_t             desc_in;
  slcfp_pkg::desc_t             desc_out;
  slcfp_pkg::rel_t              rel;

  // The register port never waits. A write lands at the access cycle; the
  // word address selects the register and the low address bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q  <= slcfp_pkg::SYNC_RESET;
      limit_q <= slcfp_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        slcfp_pkg::REG_SYNC:  sync_q  <= pwdata[slcfp_pkg::BYTE_W-1:0];
        slcfp_pkg::REG_LIMIT: limit_q <= pwdata[slcfp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      slcfp_pkg::REG_SYNC:  prdata = slcfp_pkg::DATA_W'(sync_q);
      slcfp_pkg::REG_LIMIT: prdata = slcfp_pkg::DATA_W'(limit_q);
      default:              prdata = '0;
    endcase
  end

  // The parser fills one of two payload banks while the emitter may still
  // be reading the other, so a new frame can arrive during emission.
  slcfp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sync_value_i   (sync_q),
    .length_limit_i (limit_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .push_o         (push),
    .desc_o         (desc_in),
    .fifo_full_i    (fifo_full),
    .rel_i          (rel)
  );

  // Checked frames wait here; a frame enters only once its checksum matched.
  slcfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .desc_o  (desc_out)
  );

  slcfp_ram #(
    .WIDTH (slcfp_pkg::BYTE_W),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The emitter's output register holds a result while the parser keeps
  // taking bytes; a finished bank is handed back when its last result goes.
  slcfp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_empty_i    (fifo_empty),
    .desc_i          (desc_out),
    .pop_o           (pop),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .rel_o           (rel),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_command_o (frame_command_o),
    .frame_length_o  (frame_length_o),
    .byte_index_o    (byte_index_o),
    .payload_byte_o  (payload_byte_o),
    .has_payload_o   (has_payload_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the sync / length / checksum frame parser.
// Depends on slcfp_pkg and the parser RTL; a scoreboard class predicts every result transfer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 8;
  localparam int MAX_PAYLOAD   = 32;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;

  // One result transfer of the parser, field by field.
  typedef struct packed {
    logic [slcfp_pkg::BYTE_W-1:0] command;
    logic [slcfp_pkg::LEN_W-1:0]  length;
    logic [slcfp_pkg::IDX_W-1:0]  index;
    logic [slcfp_pkg::BYTE_W-1:0] data;
    logic                         has_data;
    logic                         last;
  } frame_result_t;

  // Ways a generated frame can be damaged on purpose.
  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_CHECK,
    FLAW_SYNC_CHECK,
    FLAW_LONG,
    FLAW_CUT
  } frame_flaw_e;

  // Tracks the parser state byte by byte and holds the results still owed by the block.
  class frame_scoreboard;
    logic [slcfp_pkg::BYTE_W-1:0] sync_byte;
    logic [slcfp_pkg::LEN_W-1:0]  length_limit;
    slcfp_pkg::phase_e            phase;
    logic [slcfp_pkg::BYTE_W-1:0] command;
    logic [slcfp_pkg::LEN_W-1:0]  length;
    logic [slcfp_pkg::LEN_W-1:0]  fill_index;
    logic [slcfp_pkg::BYTE_W-1:0] running_total;
    logic [slcfp_pkg::BYTE_W-1:0] store [MAX_PAYLOAD];
    frame_result_t                expected_q[$];
    int unsigned                  failures;

    function new();
      sync_byte     = slcfp_pkg::SYNC_RESET;
      length_limit  = slcfp_pkg::LIMIT_RESET;
      phase         = slcfp_pkg::PH_SYNC;
      command       = '0;
      length        = '0;
      fill_index    = '0;
      running_total = '0;
      failures      = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void write_setting(logic reg_index, logic [slcfp_pkg::DATA_W-1:0] value);
      if (reg_index == slcfp_pkg::REG_SYNC) begin
        sync_byte = value[slcfp_pkg::BYTE_W-1:0];
      end else begin
        length_limit = value[slcfp_pkg::LEN_W-1:0];
      end
    endfunction

    // The limit never exceeds the payload store.
    function int unsigned usable_limit();
      return (length_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : length_limit;
    endfunction

    // A dropped frame restarts the header when its last byte is the sync value.
    function void start_or_hunt(logic [slcfp_pkg::BYTE_W-1:0] b);
      if (b == sync_byte) begin
        fill_index    = '0;
        running_total = '0;
        phase         = slcfp_pkg::PH_CMD;
      end else begin
        phase = slcfp_pkg::PH_SYNC;
      end
    endfunction

    function void push_result(logic [slcfp_pkg::IDX_W-1:0] index,
                              logic [slcfp_pkg::BYTE_W-1:0] data,
                              logic has_data, logic last);
      frame_result_t r;
      r.command  = command;
      r.length   = length;
      r.index    = index;
      r.data     = data;
      r.has_data = has_data;
      r.last     = last;
      expected_q.push_back(r);
    endfunction

    function void note_byte(logic [slcfp_pkg::BYTE_W-1:0] b);
      case (phase)
        slcfp_pkg::PH_CMD: begin
          command       = b;
          running_total = b;
          phase         = slcfp_pkg::PH_LEN;
        end
        slcfp_pkg::PH_LEN: begin
          if (b > usable_limit()) begin
            start_or_hunt(b);
          end else begin
            length        = b[slcfp_pkg::LEN_W-1:0];
            running_total = running_total + b;
            phase         = (b == 0) ? slcfp_pkg::PH_CHECK : slcfp_pkg::PH_DATA;
          end
        end
        slcfp_pkg::PH_DATA: begin
          if (fill_index < MAX_PAYLOAD) store[fill_index[slcfp_pkg::IDX_W-1:0]] = b;
          fill_index    = fill_index + 1'b1;
          running_total = running_total + b;
          if (fill_index >= length) phase = slcfp_pkg::PH_CHECK;
        end
        slcfp_pkg::PH_CHECK: begin
          if (b == ~running_total) begin
            if (length == 0) begin
              push_result('0, '0, 1'b0, 1'b1);
            end else begin
              for (int i = 0; i < length; i++) begin
                push_result(i[slcfp_pkg::IDX_W-1:0], store[i], 1'b1, (i + 1) == length);
              end
            end
            phase = slcfp_pkg::PH_SYNC;
          end else begin
            start_or_hunt(b);
          end
        end
        default: start_or_hunt(b);
      endcase
    endfunction

    function void compare(string name, logic [slcfp_pkg::BYTE_W-1:0] want,
                          logic [slcfp_pkg::BYTE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: command %0d index %0d", got.command, got.index);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      compare("frame_command", want.command, got.command);
      compare("frame_length", want.length, got.length);
      compare("byte_index", want.index, got.index);
      compare("payload_byte", want.data, got.data);
      compare("has_payload", want.has_data, got.has_data);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [slcfp_pkg::BYTE_W-1:0] rx_byte;
  logic                         out_valid;
  logic                         out_ready;
  logic [slcfp_pkg::BYTE_W-1:0] frame_command;
  logic [slcfp_pkg::LEN_W-1:0]  frame_length;
  logic [slcfp_pkg::IDX_W-1:0]  byte_index;
  logic [slcfp_pkg::BYTE_W-1:0] payload_byte;
  logic                         has_payload;
  logic                         last;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [slcfp_pkg::ADDR_W-1:0] paddr;
  logic [slcfp_pkg::DATA_W-1:0] pwdata;
  logic [slcfp_pkg::DATA_W-1:0] prdata;
  logic                         pready;

  frame_scoreboard              board = new();
  logic [slcfp_pkg::BYTE_W-1:0] stream_q[$];
  int unsigned                  bytes_sent = 0;
  int unsigned                  cycles = 0;
  bit                           idle_allowed;
  bit                           frame_gaps;
  bit                           rx_stalls;
  bit                           hold_req;

  sync_length_checksum_frame_parser_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_command_o(frame_command),
    .frame_length_o (frame_length),
    .byte_index_o   (byte_index),
    .payload_byte_o (payload_byte),
    .has_payload_o  (has_payload),
    .last_o         (last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL sync_length_checksum_frame_parser_core");
      $finish;
    end
  end

  // Both channels are observed at the same edge. Inputs are noted first; a result can never
  // depend on a byte taken at the same edge, so the order only keeps the queue tidy.
  always @(posedge clk) begin
    frame_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) board.note_byte(rx_byte);
      if (out_valid && out_ready) begin
        got.command  = frame_command;
        got.length   = frame_length;
        got.index    = byte_index;
        got.data     = payload_byte;
        got.has_data = has_payload;
        got.last     = last;
        board.check_result(got);
      end
    end
  end

  // Result receiver. It stalls in short random bursts while stalls are allowed, and on
  // request it holds off for a long stretch so the parser backs up and stalls its input.
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Register write: setup cycle, then access cycle. pready is always high, so the write
  // lands at the end of the access cycle.
  task automatic write_reg(logic reg_index, logic [slcfp_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_setting(reg_index, value);
  endtask

  // Offers one byte and holds it until the transfer happens. Valid stays high into the next
  // byte unless a random gap follows.
  task automatic send_byte(logic [slcfp_pkg::BYTE_W-1:0] b);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (idle_allowed && frame_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic flush_bytes();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  // Stops offering bytes and waits until every owed result has come out, plus some slack
  // for bytes that produce nothing but may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Appends one frame to the byte stream. A negative fill gives random payload bytes.
  function automatic void add_frame(logic [slcfp_pkg::BYTE_W-1:0] command,
                                    logic [slcfp_pkg::BYTE_W-1:0] len_byte,
                                    frame_flaw_e flaw, bit with_sync = 1'b1, int fill = -1);
    logic [slcfp_pkg::BYTE_W-1:0] total;
    logic [slcfp_pkg::BYTE_W-1:0] data;
    logic [slcfp_pkg::BYTE_W-1:0] check;
    int                           cut_at;
    if (with_sync) stream_q.push_back(board.sync_byte);
    stream_q.push_back(command);
    stream_q.push_back(len_byte);
    if (flaw == FLAW_LONG) return;
    total  = command + len_byte;
    cut_at = (flaw == FLAW_CUT) ? $urandom_range(0, len_byte) : -1;
    for (int i = 0; i < len_byte; i++) begin
      if (i == cut_at) return;
      data = (fill < 0) ? 8'($urandom) : 8'(fill);
      stream_q.push_back(data);
      total = total + data;
    end
    if (cut_at == len_byte) return;
    check = ~total;
    if (flaw == FLAW_BAD_CHECK) begin
      check = check ^ 8'($urandom_range(1, 255));
    end else if (flaw == FLAW_SYNC_CHECK && check != board.sync_byte) begin
      check = board.sync_byte;
    end
    stream_q.push_back(check);
  endfunction

  // Mostly good frames with random content and short lengths; the rest are damaged
  // frames and line noise.
  function automatic void random_frame();
    int unsigned                  usable;
    int unsigned                  len;
    int unsigned                  pick;
    logic [slcfp_pkg::BYTE_W-1:0] command;
    usable  = board.usable_limit();
    pick    = $urandom_range(0, 99);
    command = 8'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      len = usable;
    end else begin
      len = $urandom_range(0, (usable < 8) ? usable : 8);
    end
    if (pick < 70) begin
      add_frame(command, len, FLAW_NONE);
    end else if (pick < 78) begin
      add_frame(command, len, FLAW_BAD_CHECK);
    end else if (pick < 83) begin
      // The bad checksum doubles as a sync byte, so a header follows at once.
      add_frame(command, len, FLAW_SYNC_CHECK);
      add_frame(8'($urandom), $urandom_range(0, usable), FLAW_NONE, 1'b0);
    end else if (pick < 90) begin
      if (board.sync_byte > usable && $urandom_range(0, 1) == 1) begin
        // An oversized length equal to the sync value starts a new header.
        add_frame(command, board.sync_byte, FLAW_LONG);
        add_frame(8'($urandom), $urandom_range(0, usable), FLAW_NONE, 1'b0);
      end else begin
        add_frame(command, 8'($urandom_range(usable + 1, 255)), FLAW_LONG);
      end
    end else if (pick < 95) begin
      add_frame(command, len, FLAW_CUT);
    end else begin
      repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom));
    end
  endfunction

  task automatic random_until(int unsigned target);
    while (bytes_sent < target) begin
      frame_gaps = ($urandom_range(0, 3) != 0);
      random_frame();
      flush_bytes();
    end
  endtask

  initial begin
    in_valid     = 1'b0;
    rx_byte      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_allowed = 1'b1;
    frame_gaps   = 1'b1;
    rx_stalls    = 1'b1;
    hold_req     = 1'b0;
    rst_n        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: empty frame, one all-ones byte, length one past the limit,
    // a length equal to the sync value, and a bad checksum that equals the sync value.
    add_frame(8'hFF, 8'd0, FLAW_NONE);
    add_frame(8'h00, 8'd1, FLAW_NONE, 1'b1, 8'hFF);
    add_frame(8'h3C, 8'd33, FLAW_LONG);
    add_frame(8'h5A, board.sync_byte, FLAW_LONG);
    add_frame(8'h11, 8'd2, FLAW_NONE, 1'b0, 8'h00);
    add_frame(8'h77, 8'd0, FLAW_SYNC_CHECK);
    add_frame(8'h80, 8'd0, FLAW_NONE, 1'b0);
    flush_bytes();
    settle();

    // Low extremes: sync value zero, only empty frames accepted.
    write_reg(slcfp_pkg::REG_SYNC, 32'h0000_0000);
    write_reg(slcfp_pkg::REG_LIMIT, 32'h0000_0000);
    add_frame(8'hA5, 8'd0, FLAW_NONE);
    add_frame(8'hA5, 8'd1, FLAW_LONG);
    flush_bytes();
    random_until(110);
    settle();

    // High extremes: the limit lies above the store size, so 32 stays the real limit.
    write_reg(slcfp_pkg::REG_SYNC, 32'h0000_00FF);
    write_reg(slcfp_pkg::REG_LIMIT, 32'h0000_003F);
    add_frame(8'($urandom), 8'd32, FLAW_NONE);
    add_frame(8'($urandom), 8'd33, FLAW_LONG);
    flush_bytes();
    random_until(250);
    settle();

    // Random settings with a long receiver hold while bytes keep coming.
    write_reg(slcfp_pkg::REG_SYNC, $urandom_range(0, 255));
    write_reg(slcfp_pkg::REG_LIMIT, $urandom_range(1, 32));
    hold_req = 1'b1;
    random_until(370);
    settle();

    // Closing stretch at full rate on both sides.
    idle_allowed = 1'b0;
    rx_stalls    = 1'b0;
    write_reg(slcfp_pkg::REG_SYNC, $urandom_range(0, 255));
    write_reg(slcfp_pkg::REG_LIMIT, slcfp_pkg::LIMIT_RESET);
    random_until(460);
    settle();

    if (board.failures == 0) begin
      $display("PASS sync_length_checksum_frame_parser_core");
    end else begin
      $display("FAIL sync_length_checksum_frame_parser_core");
    end
    $finish;
  end

endmodule
